// ===== src/erff_pkg.sv =====
// Shared types and constants for the receive frame filter.
// No dependencies; every module of the filter imports this package.
package erff_pkg;

  // Fixed field widths and limits.
  localparam int unsigned MacW      = 48;
  localparam int unsigned TypeW     = 16;
  localparam int unsigned PortMax   = 4;
  localparam int unsigned HandMax   = 2;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 48;
  localparam logic [MacW-1:0] BcastMac = 48'hFFFF_FFFF_FFFF;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_PORT_FLAGS     = 3'd0,
    REG_MAC_0          = 3'd1,
    REG_MAC_1          = 3'd2,
    REG_MAC_2          = 3'd3,
    REG_MAC_3          = 3'd4,
    REG_HANDLER_COUNT  = 3'd5,
    REG_HANDLER_TYPE_0 = 3'd6,
    REG_HANDLER_TYPE_1 = 3'd7
  } erff_reg_e;

  // Frame verdict codes.
  typedef enum logic [1:0] {
    ACT_OWN_SRC  = 2'd0,
    ACT_NOT_ADDR = 2'd1,
    ACT_ACCEPT   = 2'd2
  } erff_action_e;

  // One received frame header.
  typedef struct packed {
    logic [MacW-1:0]  dst_mac;
    logic [MacW-1:0]  src_mac;
    logic [TypeW-1:0] ether_type;
    logic [1:0]       ingress_port;
  } erff_in_t;

  // One filter verdict.
  typedef struct packed {
    erff_action_e action;
    logic [3:0]   flood_mask;
    logic         handler_hit;
    logic         handler_index;
  } erff_res_t;

  // Comparison results handed from the compare stage to the decision stage.
  typedef struct packed {
    logic [PortMax-1:0] src_hit;
    logic [PortMax-1:0] dst_hit;
    logic               bcast;
    logic [PortMax-1:0] flood_cand;
    logic [HandMax-1:0] type_hit;
  } erff_cmp_t;

endpackage

// ===== src/erff_compare.sv =====
// Compare stage of the receive frame filter: MAC and ethertype matches.
// Depends on erff_pkg.
module erff_compare import erff_pkg::*; #(
  parameter int unsigned PORTS    = 4,
  parameter int unsigned HANDLERS = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  erff_in_t                       hdr_i,
  input  logic [7:0]                     port_flags_i,
  input  logic [PORTS-1:0][MacW-1:0]     mac_i,
  input  logic [1:0]                     handler_count_i,
  input  logic [HANDLERS-1:0][TypeW-1:0] handler_type_i,
  output logic                           valid_o,
  output erff_cmp_t                      cmp_o
);

  logic [PortMax-1:0] src_hit;
  logic [PortMax-1:0] dst_hit;
  logic [PortMax-1:0] flood_cand;
  logic [PortMax-1:0] ingress_oh;
  logic [HandMax-1:0] type_hit;
  logic [1:0]         hcnt;
  erff_cmp_t          cmp_d;
  erff_cmp_t          cmp_q;
  logic               valid_q;

  assign ingress_oh = 4'b0001 << hdr_i.ingress_port;

  // Per-port address matches; ports beyond the configured count never match.
  for (genvar p = 0; p < PortMax; p++) begin : g_port
    if (p < PORTS) begin : g_on
      assign src_hit[p] = port_flags_i[p] && (mac_i[p] == hdr_i.src_mac);
      assign dst_hit[p] = port_flags_i[p] && (mac_i[p] == hdr_i.dst_mac);
      assign flood_cand[p] = port_flags_i[p] && !port_flags_i[p+PortMax] && !ingress_oh[p];
    end else begin : g_off
      assign src_hit[p]    = 1'b0;
      assign dst_hit[p]    = 1'b0;
      assign flood_cand[p] = 1'b0;
    end
  end

  // The slot count saturates at the number of slots built.
  assign hcnt = (handler_count_i > 2'(HANDLERS)) ? 2'(HANDLERS) : handler_count_i;

  // Ethertype matches for the slots in use.
  for (genvar h = 0; h < HandMax; h++) begin : g_hand
    if (h < HANDLERS) begin : g_on
      assign type_hit[h] = (2'(h) < hcnt) && (handler_type_i[h] == hdr_i.ether_type);
    end else begin : g_off
      assign type_hit[h] = 1'b0;
    end
  end

  // Gather the match vectors for the next stage.
  always_comb begin
    cmp_d            = '0;
    cmp_d.src_hit    = src_hit;
    cmp_d.dst_hit    = dst_hit;
    cmp_d.bcast      = (hdr_i.dst_mac == BcastMac);
    cmp_d.flood_cand = flood_cand;
    cmp_d.type_hit   = type_hit;
  end

  // Stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      cmp_q <= cmp_d;
    end
  end

  assign valid_o = valid_q;
  assign cmp_o   = cmp_q;

endmodule

// ===== src/ethernet_rx_frame_filter_unit.sv =====
// Top level of the receive frame filter: configuration registers and pipeline.
// Depends on erff_pkg and erff_compare.
//
// The filter classifies one frame header per clock cycle through a three-stage
// pipeline: header capture, MAC and ethertype compare, verdict. Each header
// produces exactly one verdict, presented on res_o with done_o high for one
// cycle. That cycle begins once the header has passed the capture, compare and
// verdict registers, and the verdict beat is taken at the edge that ends it.
// The pipeline never stalls and busy_o stays low, so start_i may be held high
// every cycle; the receiver must take each verdict in the cycle it appears.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i and must
// only change while no header is in flight.
module ethernet_rx_frame_filter_unit import erff_pkg::*; #(
  parameter int unsigned PORTS    = 4,
  parameter int unsigned HANDLERS = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  erff_in_t            in_i,
  output logic                done_o,
  output erff_res_t           res_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  logic [7:0]                     port_flags_q;
  logic [PORTS-1:0][MacW-1:0]     mac_q;
  logic [1:0]                     handler_count_q;
  logic [HANDLERS-1:0][TypeW-1:0] handler_type_q;

  logic      in_valid_q;
  erff_in_t  hdr_q;
  logic      cmp_valid;
  erff_cmp_t cmp;
  logic      res_valid_q;
  erff_res_t res_d;
  erff_res_t res_q;
  logic      own_src;
  logic      addressed;

  assign busy_o = 1'b0;

  // Scalar configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_flags_q    <= '0;
      handler_count_q <= '0;
    end else if (cfg_we_i) begin
      case (erff_reg_e'(cfg_idx_i))
        REG_PORT_FLAGS:    port_flags_q    <= cfg_wdata_i[7:0];
        REG_HANDLER_COUNT: handler_count_q <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // Interface MAC registers, one per built port.
  for (genvar p = 0; p < PORTS; p++) begin : g_mac
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mac_q[p] <= '0;
      end else if (cfg_we_i && (cfg_idx_i == 3'(REG_MAC_0) + 3'(p))) begin
        mac_q[p] <= cfg_wdata_i[MacW-1:0];
      end
    end
  end

  // Ethertype handler registers, one per built slot.
  for (genvar h = 0; h < HANDLERS; h++) begin : g_type
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        handler_type_q[h] <= '0;
      end else if (cfg_we_i && (cfg_idx_i == 3'(REG_HANDLER_TYPE_0) + 3'(h))) begin
        handler_type_q[h] <= cfg_wdata_i[TypeW-1:0];
      end
    end
  end

  // Stage one: capture the header beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      hdr_q <= in_i;
    end
  end

  // Stage two: address and ethertype compares.
  erff_compare #(
    .PORTS    (PORTS),
    .HANDLERS (HANDLERS)
  ) u_compare (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (in_valid_q),
    .hdr_i           (hdr_q),
    .port_flags_i    (port_flags_q),
    .mac_i           (mac_q),
    .handler_count_i (handler_count_q),
    .handler_type_i  (handler_type_q),
    .valid_o         (cmp_valid),
    .cmp_o           (cmp)
  );

  // Stage three: verdict, flood mask and handler selection.
  assign own_src   = |cmp.src_hit;
  assign addressed = cmp.bcast || (|cmp.dst_hit);

  always_comb begin
    res_d = '0;
    if (own_src) begin
      res_d.action = ACT_OWN_SRC;
    end else if (!addressed) begin
      res_d.action = ACT_NOT_ADDR;
    end else begin
      res_d.action        = ACT_ACCEPT;
      res_d.flood_mask    = cmp.bcast ? cmp.flood_cand : 4'b0000;
      res_d.handler_hit   = |cmp.type_hit;
      res_d.handler_index = !cmp.type_hit[0] && cmp.type_hit[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmp_valid) begin
      res_q <= res_d;
    end
  end

  assign done_o = res_valid_q;
  assign res_o  = res_q;

endmodule

// ===== tb/sv/erff_tb_pkg.sv =====
// Verdict checker for the receive frame filter testbench.
// Depends on erff_pkg for the header and verdict types and register indexes.
package erff_tb_pkg;
  import erff_pkg::*;

  // Keeps a copy of the filter registers and predicts one verdict per header.
  class verdict_checker;
    logic [7:0]       port_flags = '0;
    logic [MacW-1:0]  port_mac [PortMax] = '{default: '0};
    logic [1:0]       handler_count = '0;
    logic [TypeW-1:0] handler_type [HandMax] = '{default: '0};
    erff_res_t        pending_verdicts [$];
    int unsigned      mismatches = 0;

    // Mirror one register write, keeping only the register's own width.
    function void write_reg(erff_reg_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_PORT_FLAGS:     port_flags = data[7:0];
        REG_MAC_0:          port_mac[0] = data[MacW-1:0];
        REG_MAC_1:          port_mac[1] = data[MacW-1:0];
        REG_MAC_2:          port_mac[2] = data[MacW-1:0];
        REG_MAC_3:          port_mac[3] = data[MacW-1:0];
        REG_HANDLER_COUNT:  handler_count = data[1:0];
        REG_HANDLER_TYPE_0: handler_type[0] = data[TypeW-1:0];
        REG_HANDLER_TYPE_1: handler_type[1] = data[TypeW-1:0];
        default: ;
      endcase
    endfunction

    // An address is ours when a present port carries it.
    function bit is_own_mac(logic [MacW-1:0] mac);
      for (int p = 0; p < PortMax; p++) begin
        if (port_flags[p] && port_mac[p] == mac) return 1'b1;
      end
      return 1'b0;
    endfunction

    // Work out the verdict for an accepted header and queue it.
    function void note_header(erff_in_t hdr);
      erff_res_t   verdict;
      int unsigned slots;
      bit          found;
      verdict = '0;
      found = 1'b0;
      if (is_own_mac(hdr.src_mac)) begin
        verdict.action = ACT_OWN_SRC;
      end else if (hdr.dst_mac != BcastMac && !is_own_mac(hdr.dst_mac)) begin
        verdict.action = ACT_NOT_ADDR;
      end else begin
        verdict.action = ACT_ACCEPT;
        // Broadcasts flood to present, non-loopback ports except the ingress one.
        if (hdr.dst_mac == BcastMac) begin
          for (int p = 0; p < PortMax; p++) begin
            if (port_flags[p] && !port_flags[p+4] && p != int'(hdr.ingress_port))
              verdict.flood_mask[p] = 1'b1;
          end
        end
        // A slot count above the number of slots saturates.
        slots = (handler_count > HandMax) ? HandMax : handler_count;
        for (int h = 0; h < slots; h++) begin
          if (!found && handler_type[h] == hdr.ether_type) begin
            found = 1'b1;
            verdict.handler_hit = 1'b1;
            verdict.handler_index = h[0];
          end
        end
      end
      pending_verdicts.push_back(verdict);
    endfunction

    // Compare one verdict from the block with the oldest prediction.
    function void check_verdict(erff_res_t got);
      erff_res_t want;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected verdict: action %0d flood %b hit %0d index %0d",
                   got.action, got.flood_mask, got.handler_hit, got.handler_index);
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.action !== want.action || got.flood_mask !== want.flood_mask ||
          got.handler_hit !== want.handler_hit ||
          got.handler_index !== want.handler_index) begin
        mismatches++;
        if (mismatches <= 10)
          $display("verdict mismatch: expected action %0d flood %b hit %0d index %0d, got action %0d flood %b hit %0d index %0d",
                   want.action, want.flood_mask, want.handler_hit, want.handler_index,
                   got.action, got.flood_mask, got.handler_hit, got.handler_index);
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_ethernet_rx_frame_filter_unit.sv =====
// Testbench top for the receive frame filter: directed headers, then random phases.
// Depends on erff_pkg, erff_tb_pkg and ethernet_rx_frame_filter_unit.
module tb_ethernet_rx_frame_filter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import erff_pkg::*;
  import erff_tb_pkg::*;

  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned PhaseCount    = 12;
  localparam int unsigned ItemsPerPhase = 157;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  erff_in_t            in_i = '0;
  logic                done_o;
  erff_res_t           res_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  verdict_checker chk = new;
  int unsigned    headers_taken = 0;
  int unsigned    cycle_count = 0;
  bit             idle_on = 1'b1;

  ethernet_rx_frame_filter_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .in_i       (in_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Free-running clock, 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watch both sides at the rising edge: accepted headers and verdict beats.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        chk.note_header(in_i);
        headers_taken <= headers_taken + 1;
      end
      if (done_o) chk.check_verdict(res_o);
    end
  end

  // Watchdog against a hung block.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Write one register at the next rising edge and mirror it in the checker.
  task automatic write_reg(erff_reg_e idx, logic [CfgDataW-1:0] data);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    chk.write_reg(idx, data);
  endtask

  // Offer one header after a random gap and hold it until it is taken.
  task automatic send_header(erff_in_t hdr);
    int unsigned gap;
    int unsigned target;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i = 1'b1;
    in_i = hdr;
    target = headers_taken + 1;
    do @(negedge clk_i); while (headers_taken < target);
  endtask

  // Stop sending and wait until every predicted verdict has come back.
  task automatic drain();
    start_i = 1'b0;
    while (chk.pending_verdicts.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [MacW-1:0] rand_mac();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return MacW'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [TypeW-1:0] rand_type();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return TypeW'($urandom);
    endcase
  endfunction

  // Pick a register setting for one random phase; some phases pin extremes.
  task automatic random_config(int unsigned phase);
    logic [7:0]       flags;
    logic [MacW-1:0]  mac [PortMax];
    logic [1:0]       count;
    logic [TypeW-1:0] etype [HandMax];
    flags = 8'($urandom);
    count = 2'($urandom);
    for (int p = 0; p < PortMax; p++) begin
      mac[p] = rand_mac();
      // Now and then two ports share an address.
      if (p > 0 && $urandom_range(0, 5) == 0) mac[p] = mac[p-1];
    end
    etype[0] = rand_type();
    etype[1] = ($urandom_range(0, 3) == 0) ? etype[0] : rand_type();
    case (phase)
      0: begin
        flags = 8'h00;
        count = 2'd0;
      end
      1: begin
        flags = 8'hFF;
        count = 2'd3;
      end
      2: begin
        flags = 8'h0F;
        count = 2'd2;
      end
      3: flags = 8'hF0;
      4: begin
        flags = 8'h0F;
        count = 2'd0;
        for (int p = 0; p < PortMax; p++) mac[p] = '0;
        etype = '{default: '0};
      end
      PhaseCount - 1: begin
        flags = 8'h0F;
        count = 2'd2;
        for (int p = 0; p < PortMax; p++) mac[p] = '1;
        etype = '{default: '1};
      end
      default: ;
    endcase
    // Upper data bits beyond a register's width carry noise.
    write_reg(REG_PORT_FLAGS, {40'($urandom), flags});
    write_reg(REG_MAC_0, mac[0]);
    write_reg(REG_MAC_1, mac[1]);
    write_reg(REG_MAC_2, mac[2]);
    write_reg(REG_MAC_3, mac[3]);
    write_reg(REG_HANDLER_COUNT, {46'({$urandom, $urandom}), count});
    write_reg(REG_HANDLER_TYPE_0, {32'($urandom), etype[0]});
    write_reg(REG_HANDLER_TYPE_1, {32'($urandom), etype[1]});
  endtask

  // Random header biased toward broadcasts, port addresses and handled types.
  function automatic erff_in_t random_header();
    erff_in_t hdr;
    hdr.ingress_port = 2'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: hdr.dst_mac = BcastMac;
      4, 5, 6:    hdr.dst_mac = chk.port_mac[$urandom_range(0, PortMax - 1)];
      default:    hdr.dst_mac = rand_mac();
    endcase
    if ($urandom_range(0, 9) < 3) hdr.src_mac = chk.port_mac[$urandom_range(0, PortMax - 1)];
    else hdr.src_mac = rand_mac();
    if ($urandom_range(0, 1) == 0) hdr.ether_type = chk.handler_type[$urandom_range(0, 1)];
    else hdr.ether_type = rand_type();
    return hdr;
  endfunction

  // Main sequence.
  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Registers at reset: nothing is local, a broadcast is accepted without flooding.
    send_header(erff_in_t'{BcastMac, 48'h0, 16'h0800, 2'd1});
    drain();

    // Ports 0 to 2 present, port 2 loopback, port 3 absent; two handler slots.
    write_reg(REG_PORT_FLAGS, 48'h47);
    write_reg(REG_MAC_0, 48'h0200_0000_0001);
    write_reg(REG_MAC_1, 48'h0200_0000_0002);
    write_reg(REG_MAC_2, 48'h0200_0000_0003);
    write_reg(REG_MAC_3, 48'h0200_0000_0004);
    write_reg(REG_HANDLER_COUNT, 48'd2);
    write_reg(REG_HANDLER_TYPE_0, 48'h0800);
    write_reg(REG_HANDLER_TYPE_1, 48'h0806);

    // Own source, absent port's address, unicast miss, broadcast from each port.
    send_header(erff_in_t'{48'h0200_0000_0002, 48'h0200_0000_0001, 16'h0800, 2'd0});
    send_header(erff_in_t'{48'h0200_0000_0002, 48'h0200_0000_0004, 16'h0800, 2'd1});
    send_header(erff_in_t'{48'h0200_0000_0004, 48'h1234_5678_9ABC, 16'h0800, 2'd3});
    send_header(erff_in_t'{48'h0A0B_0C0D_0E0F, 48'h1234_5678_9ABC, 16'h0806, 2'd0});
    send_header(erff_in_t'{BcastMac, 48'h1234_5678_9ABC, 16'h0800, 2'd0});
    send_header(erff_in_t'{BcastMac, 48'h1234_5678_9ABC, 16'h0800, 2'd1});
    send_header(erff_in_t'{BcastMac, 48'h1234_5678_9ABC, 16'h0806, 2'd2});
    send_header(erff_in_t'{BcastMac, 48'h1234_5678_9ABC, 16'h0806, 2'd3});
    // Handler hits and misses, loopback port as destination, field extremes.
    send_header(erff_in_t'{48'h0200_0000_0001, 48'h0, 16'h0806, 2'd2});
    send_header(erff_in_t'{48'h0200_0000_0003, 48'h0, 16'h1234, 2'd0});
    send_header(erff_in_t'{48'h0, 48'h0, 16'h0, 2'd0});
    send_header(erff_in_t'{BcastMac, BcastMac, 16'hFFFF, 2'd3});
    send_header(erff_in_t'{BcastMac, 48'h5555_5555_5555, 16'h0, 2'd1});
    send_header(erff_in_t'{BcastMac, 48'h0200_0000_0002, 16'h0800, 2'd0});
    send_header(erff_in_t'{48'hAAAA_AAAA_AAAA, 48'h0200_0000_0003, 16'hAAAA, 2'd2});
    drain();

    // Slot count above the number of slots, both slots on one type.
    write_reg(REG_HANDLER_COUNT, 48'd3);
    write_reg(REG_HANDLER_TYPE_0, 48'h88CC);
    write_reg(REG_HANDLER_TYPE_1, 48'h88CC);
    send_header(erff_in_t'{BcastMac, 48'h0, 16'h88CC, 2'd2});
    send_header(erff_in_t'{48'h0200_0000_0001, 48'h0, 16'h88CC, 2'd0});
    drain();

    // One slot in use: the second slot's type must not hit.
    write_reg(REG_HANDLER_COUNT, 48'd1);
    write_reg(REG_HANDLER_TYPE_1, 48'h0806);
    send_header(erff_in_t'{48'h0200_0000_0002, 48'h0, 16'h0806, 2'd0});
    send_header(erff_in_t'{48'h0200_0000_0002, 48'h0, 16'h88CC, 2'd0});
    drain();

    // Random phases, each under its own setting; every third runs without gaps.
    for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
      random_config(phase);
      idle_on = (phase % 3 != 1);
      repeat (ItemsPerPhase) send_header(random_header());
      drain();
    end

    if (chk.mismatches == 0 && chk.pending_verdicts.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
